FILE: design/cbl_pkg.sv
// Package for the cascaded biquad band limiter.
// Holds the fixed-point widths, register indexes and control types; no dependencies.
package cbl_pkg;

  localparam int SAMP_W  = 28;  // Q5.23 samples between sections and in history
  localparam int IO_W    = 24;  // Q1.23 samples at the ports
  localparam int COEF_W  = 32;  // Q2.30 coefficients
  localparam int MCOEF_W = 34;  // coefficient after doubling and negation
  localparam int PROD_W  = MCOEF_W + SAMP_W;
  localparam int ACC_W   = 64;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 4;
  localparam int ORD_W   = 4;
  localparam int STG_W   = 4;
  localparam int CH_W    = 3;
  localparam int HIST_W  = 4 * SAMP_W;

  localparam logic [IDX_W-1:0] REG_HP_ORDER  = 4'd0;
  localparam logic [IDX_W-1:0] REG_LP_ORDER  = 4'd1;
  localparam logic [IDX_W-1:0] REG_HP_FIRST  = 4'd2;
  localparam logic [IDX_W-1:0] REG_HP_GAIN   = 4'd3;
  localparam logic [IDX_W-1:0] REG_HP_A2     = 4'd4;
  localparam logic [IDX_W-1:0] REG_LP_FIRST  = 4'd5;
  localparam logic [IDX_W-1:0] REG_LP_GAIN   = 4'd6;
  localparam logic [IDX_W-1:0] REG_LP_A2     = 4'd7;

  typedef enum logic [2:0] {
    TERM_X0,
    TERM_X1,
    TERM_X2,
    TERM_Y1,
    TERM_Y2
  } term_t;

  typedef struct packed {
    logic [ORD_W-1:0] hp_order;
    logic [ORD_W-1:0] lp_order;
    logic [CFG_W-1:0] hp_first;
    logic [CFG_W-1:0] hp_gain;
    logic [CFG_W-1:0] hp_a2;
    logic [CFG_W-1:0] lp_first;
    logic [CFG_W-1:0] lp_gain;
    logic [CFG_W-1:0] lp_a2;
  } cfg_t;

  typedef struct packed {
    logic  load;      // take a new input sample
    logic  rd;        // read the history entry
    logic  mul;       // multiply the selected term
    term_t term;
    logic  acc_load;  // start the sum with the registered product
    logic  acc_add;   // add the registered product
    logic  wr;        // write back history and pass the section output on
    logic  clr;       // write a zero history entry
    logic  lowpass;   // 0: high-pass cascade, 1: low-pass cascade
    logic  first;     // current section is the first-order one
    logic  out_load;  // capture the final result
  } cmd_t;

endpackage

FILE: design/cbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbl_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cbl_datapath.sv
// Datapath: history RAM, coefficient selection, shared multiplier and accumulator.
// Depends on cbl_pkg and cbl_ram.
module cbl_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  cbl_pkg::cfg_t                 cfg,
  input  cbl_pkg::cmd_t                 cmd,
  input  logic [$clog2(DEPTH)-1:0]      addr,
  input  logic signed [cbl_pkg::IO_W-1:0] sample_in,
  output logic signed [cbl_pkg::IO_W-1:0] sample_out
);

  localparam int SW = cbl_pkg::SAMP_W;
  localparam int MW = cbl_pkg::MCOEF_W;
  localparam int AW = cbl_pkg::ACC_W;
  localparam int RW = AW - 30;

  logic signed [SW-1:0] x_q;
  logic [cbl_pkg::HIST_W-1:0] rdata, wdata;
  logic signed [SW-1:0] x1, x2, y1, y2, op, y;
  logic signed [MW-1:0] b0, a1, a2, coef;
  logic [cbl_pkg::CFG_W-1:0] first_r, gain_r, a2_r;
  logic signed [cbl_pkg::PROD_W-1:0] prod_q;
  logic signed [AW-1:0] acc_q, rnd;
  logic signed [RW-1:0] sh;
  logic signed [cbl_pkg::IO_W-1:0] out_q;

  cbl_ram #(.WIDTH(cbl_pkg::HIST_W), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.wr || cmd.clr),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // Entry layout from the low bits up: x1, x2, y1, y2.
  assign x1 = rdata[SW-1:0];
  assign x2 = rdata[2*SW-1:SW];
  assign y1 = rdata[3*SW-1:2*SW];
  assign y2 = rdata[4*SW-1:3*SW];
  assign wdata = cmd.clr ? '0 : {y1, y, x1, x_q};

  always_comb begin
    first_r = cmd.lowpass ? cfg.lp_first : cfg.hp_first;
    gain_r  = cmd.lowpass ? cfg.lp_gain : cfg.hp_gain;
    a2_r    = cmd.lowpass ? cfg.lp_a2 : cfg.hp_a2;
    b0 = cmd.first ? MW'($signed(first_r[63:32])) : MW'($signed(gain_r[63:32]));
    a1 = cmd.first ? MW'($signed(first_r[31:0])) : MW'($signed(gain_r[31:0]));
    a2 = cmd.first ? '0 : MW'($signed(a2_r[31:0]));
    case (cmd.term)
      cbl_pkg::TERM_X0: begin
        coef = b0;
        op   = x_q;
      end
      cbl_pkg::TERM_X1: begin
        if (cmd.first) begin
          coef = cmd.lowpass ? b0 : -b0;
        end else begin
          coef = cmd.lowpass ? (b0 <<< 1) : -(b0 <<< 1);
        end
        op = x1;
      end
      cbl_pkg::TERM_X2: begin
        coef = cmd.first ? '0 : b0;
        op   = x2;
      end
      cbl_pkg::TERM_Y1: begin
        coef = -a1;
        op   = y1;
      end
      cbl_pkg::TERM_Y2: begin
        coef = -a2;
        op   = y2;
      end
      default: begin
        coef = '0;
        op   = '0;
      end
    endcase
  end

  // Round to 23 fractional bits (floor after adding half), then saturate to Q5.23.
  always_comb begin
    rnd = acc_q + (AW'(1) <<< 29);
    sh  = RW'(rnd >>> 30);
    if (sh > RW'((1 <<< (SW - 1)) - 1)) begin
      y = {1'b0, {(SW-1){1'b1}}};
    end else if (sh < -RW'(1 <<< (SW - 1))) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = sh[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q <= SW'(sample_in);
    end else if (cmd.wr) begin
      x_q <= y;
    end
    if (cmd.mul) begin
      prod_q <= coef * op;
    end
    if (cmd.acc_load) begin
      acc_q <= AW'(prod_q);
    end else if (cmd.acc_add) begin
      acc_q <= acc_q + AW'(prod_q);
    end
    if (cmd.out_load) begin
      if (x_q > SW'(8388607)) begin
        out_q <= 24'sh7FFFFF;
      end else if (x_q < -SW'(8388608)) begin
        out_q <= 24'sh800000;
      end else begin
        out_q <= x_q[cbl_pkg::IO_W-1:0];
      end
    end
  end

  assign sample_out = out_q;

endmodule

FILE: design/cbl_ctrl.sv
// Controller: sequences history clearing, the sections of both cascades and output.
// Depends on cbl_pkg.
module cbl_ctrl #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_STAGES   = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cbl_pkg::CH_W-1:0]              channel,
  input  logic [cbl_pkg::ORD_W-1:0]             hp_order,
  input  logic [cbl_pkg::ORD_W-1:0]             lp_order,
  input  logic                                  order_wr,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cbl_pkg::cmd_t                         cmd,
  output logic [$clog2(2*MAX_STAGES*MAX_CHANNELS)-1:0] addr
);

  localparam int DEPTH = 2 * MAX_STAGES * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = cbl_pkg::ORD_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WAIT,
    ST_MAC,
    ST_ACC,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [cbl_pkg::CH_W-1:0] ch_q;
  logic lowpass_q;
  logic [cbl_pkg::STG_W-1:0] stage_q;
  logic [2:0] term_q;
  logic [OW-1:0] ord, ord_sat;
  logic [cbl_pkg::STG_W-1:0] nsec;
  logic first;
  logic in_range;
  logic [AW-1:0] sec_addr;

  always_comb begin
    ord = OW'(lowpass_q ? lp_order : hp_order);
    ord_sat = (ord > OW'(2 * MAX_STAGES)) ? OW'(2 * MAX_STAGES) : ord;
    nsec = cbl_pkg::STG_W'((ord_sat + OW'(1)) >> 1);
    first = ord_sat[0] && (stage_q == '0);
    in_range = 32'(ch_q) < MAX_CHANNELS;
    sec_addr = (lowpass_q ? AW'(MAX_STAGES * MAX_CHANNELS) : '0)
             + AW'(32'(stage_q) * MAX_CHANNELS) + AW'(ch_q);
    addr = (state == ST_CLEAR) ? clr_addr : sec_addr;
    in_ready = (state == ST_IDLE);
  end

  always_comb begin
    cmd = '0;
    cmd.load     = in_ready && in_valid;
    cmd.rd       = (state == ST_SETUP) && in_range && (stage_q < nsec);
    cmd.mul      = (state == ST_MAC);
    cmd.term     = cbl_pkg::term_t'(term_q);
    cmd.acc_load = (state == ST_MAC) && (term_q == 3'd1);
    cmd.acc_add  = ((state == ST_MAC) && (term_q > 3'd1)) || (state == ST_ACC);
    cmd.wr       = (state == ST_ROUND);
    cmd.clr      = (state == ST_CLEAR);
    cmd.lowpass  = lowpass_q;
    cmd.first    = first;
    cmd.out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      lowpass_q <= 1'b0;
      stage_q   <= '0;
      term_q    <= '0;
      ch_q      <= '0;
    end else begin
      // The done state reloads the output register itself when the old result leaves.
      if (out_valid && out_ready && ((state != ST_DONE) || order_wr)) begin
        out_valid <= 1'b0;
      end
      // Order writes must come while idle (unenforced); they restart the history clear.
      if (order_wr) begin
        state    <= ST_CLEAR;
        clr_addr <= '0;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + AW'(1);
            if (clr_addr == AW'(DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              ch_q      <= channel;
              lowpass_q <= 1'b0;
              stage_q   <= '0;
              state     <= ST_SETUP;
            end
          end
          ST_SETUP: begin
            term_q <= '0;
            if (!in_range) begin
              state <= ST_DONE;
            end else if (stage_q < nsec) begin
              state <= ST_WAIT;
            end else if (!lowpass_q) begin
              lowpass_q <= 1'b1;
              stage_q   <= '0;
            end else begin
              state <= ST_DONE;
            end
          end
          ST_WAIT: begin
            state <= ST_MAC;
          end
          ST_MAC: begin
            term_q <= term_q + 3'd1;
            if (term_q == 3'd4) begin
              state <= ST_ACC;
            end
          end
          ST_ACC: begin
            state <= ST_ROUND;
          end
          ST_ROUND: begin
            stage_q <= stage_q + cbl_pkg::STG_W'(1);
            state   <= ST_SETUP;
          end
          ST_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/cascaded_biquad_band_limiter_unit.sv
// The block takes one item at a time and runs S sections per item (S from 0 to 2*MAX_STAGES),
// high-pass cascade first, one after another on the shared multiplier.
// Reset is synchronous; it clears registers and then clears the history RAM in a pass over all
// 2*MAX_STAGES*MAX_CHANNELS entries with s_axis_tready low. An order write starts the same pass.
// Depends on cbl_pkg, cbl_ctrl, cbl_datapath and cbl_ram.
module cascaded_biquad_band_limiter_unit #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_STAGES   = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,   // [23:0] sample_in
  input  logic [2:0]                  s_axis_tuser,   // [2:0] channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // [23:0] sample_out
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cbl_pkg::CFG_W-1:0]   cfg_data
);

  localparam int DEPTH = 2 * MAX_STAGES * MAX_CHANNELS;

  cbl_pkg::cfg_t cfg;
  cbl_pkg::cmd_t cmd;
  logic cfg_wr;
  logic order_wr;
  logic [$clog2(DEPTH)-1:0] addr;

  // The register file accepts a transaction every cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign order_wr  = cfg_wr && (cfg_index == cbl_pkg::REG_HP_ORDER
                             || cfg_index == cbl_pkg::REG_LP_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        cbl_pkg::REG_HP_ORDER: cfg.hp_order <= cfg_data[cbl_pkg::ORD_W-1:0];
        cbl_pkg::REG_LP_ORDER: cfg.lp_order <= cfg_data[cbl_pkg::ORD_W-1:0];
        cbl_pkg::REG_HP_FIRST: cfg.hp_first <= cfg_data;
        cbl_pkg::REG_HP_GAIN:  cfg.hp_gain  <= cfg_data;
        cbl_pkg::REG_HP_A2:    cfg.hp_a2    <= cfg_data;
        cbl_pkg::REG_LP_FIRST: cfg.lp_first <= cfg_data;
        cbl_pkg::REG_LP_GAIN:  cfg.lp_gain  <= cfg_data;
        cbl_pkg::REG_LP_A2:    cfg.lp_a2    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The controller walks high-pass then low-pass sections and drives the datapath.
  cbl_ctrl #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_STAGES(MAX_STAGES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .channel   (s_axis_tuser),
    .hp_order  (cfg.hp_order),
    .lp_order  (cfg.lp_order),
    .order_wr  (order_wr),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .addr      (addr)
  );

  cbl_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .cfg        (cfg),
    .cmd        (cmd),
    .addr       (addr),
    .sample_in  (s_axis_tdata),
    .sample_out (m_axis_tdata)
  );

endmodule

FILE: design/cbl_checker.sv
// Port-level checker for the band limiter, bound to the top level.
// Depends on cbl_pkg and cascaded_biquad_band_limiter_unit.
module cbl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [23:0]               m_axis_tdata,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [cbl_pkg::IDX_W-1:0] cfg_index
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input accepted right after reset");

  a_order_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == cbl_pkg::REG_HP_ORDER
      || cfg_index == cbl_pkg::REG_LP_ORDER)) |=> !s_axis_tready)
    else $error("input accepted during history clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind cascaded_biquad_band_limiter_unit cbl_checker u_cbl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_index     (cfg_index)
);

FILE: tb/tb_cascaded_biquad_band_limiter_unit.sv
// Self-checking testbench for the cascaded biquad band limiter unit.
// Depends on cbl_pkg and the RTL of cascaded_biquad_band_limiter_unit with its submodules.
module tb_cascaded_biquad_band_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // These match the parameters passed to the block below.
  localparam int  NUM_CH       = 8;
  localparam int  NUM_STG      = 4;
  localparam int  HIST_ENTRIES = 2 * NUM_STG * NUM_CH;
  localparam int  DRAIN_CYCLES = 100;      // extra wait after the last expected result
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam longint SEC_MAX   = 134217727;
  localparam longint SEC_MIN   = -134217728;
  localparam longint PORT_MAX  = 8388607;
  localparam longint PORT_MIN  = -8388608;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [cbl_pkg::IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [cbl_pkg::IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;   // [23:0] sample_in
  logic [2:0]          s_axis_tuser = '0;   // [2:0] channel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [23:0] sample_out
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [cbl_pkg::IDX_W-1:0] cfg_index = '0;
  logic [cbl_pkg::CFG_W-1:0] cfg_data = '0;

  cascaded_biquad_band_limiter_unit #(
    .MAX_CHANNELS(NUM_CH),
    .MAX_STAGES(NUM_STG)
  ) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shared state of the test: error count, idle percentages and the receiver hold-off.
  int     error_count = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;
  int     sink_hold = 0;
  longint cycle_count = 0;
  logic [23:0] expected_samples[$];

  // Our own copy of the filter settings and the per-channel, per-stage history.
  logic [cbl_pkg::ORD_W-1:0] hp_ord, lp_ord;
  logic [cbl_pkg::CFG_W-1:0] hp_first, hp_gain, hp_a2, lp_first, lp_gain, lp_a2;
  longint hx1[HIST_ENTRIES], hx2[HIST_ENTRIES], hy1[HIST_ENTRIES], hy2[HIST_ENTRIES];

  function automatic void clear_history();
    for (int i = 0; i < HIST_ENTRIES; i++) begin
      hx1[i] = 0; hx2[i] = 0; hy1[i] = 0; hy2[i] = 0;
    end
  endfunction

  // Mirror of a register write as the block should see it.
  function automatic void apply_reg(logic [cbl_pkg::IDX_W-1:0] idx,
                                    logic [cbl_pkg::CFG_W-1:0] val);
    case (idx)
      cbl_pkg::REG_HP_ORDER: begin
        hp_ord = val[cbl_pkg::ORD_W-1:0]; clear_history();
      end
      cbl_pkg::REG_LP_ORDER: begin
        lp_ord = val[cbl_pkg::ORD_W-1:0]; clear_history();
      end
      cbl_pkg::REG_HP_FIRST: hp_first = val;
      cbl_pkg::REG_HP_GAIN:  hp_gain  = val;
      cbl_pkg::REG_HP_A2:    hp_a2    = val;
      cbl_pkg::REG_LP_FIRST: lp_first = val;
      cbl_pkg::REG_LP_GAIN:  lp_gain  = val;
      cbl_pkg::REG_LP_A2:    lp_a2    = val;
      default: ;
    endcase
  endfunction

  // One direct-form-I section: 64-bit sum that wraps like the hardware accumulator,
  // rounding to 23 fractional bits, then saturation to the 28-bit inner format.
  function automatic longint filter_section(int idx, longint x, longint b0, longint b1,
                                            longint b2, longint a1, longint a2);
    longint acc, y;
    acc = b0 * x + b1 * hx1[idx] + b2 * hx2[idx] - a1 * hy1[idx] - a2 * hy2[idx];
    y = (acc + 64'sd536870912) >>> 30;
    if (y > SEC_MAX) y = SEC_MAX;
    if (y < SEC_MIN) y = SEC_MIN;
    hx2[idx] = hx1[idx]; hx1[idx] = x;
    hy2[idx] = hy1[idx]; hy1[idx] = y;
    return y;
  endfunction

  function automatic longint filter_cascade(bit lowpass, longint x, int ch);
    logic [cbl_pkg::ORD_W-1:0] ord;
    logic [cbl_pkg::CFG_W-1:0] first, gain, a2reg;
    longint sgn, g, b0, a1, a2;
    int stage, base;
    ord   = lowpass ? lp_ord : hp_ord;
    first = lowpass ? lp_first : hp_first;
    gain  = lowpass ? lp_gain : hp_gain;
    a2reg = lowpass ? lp_a2 : hp_a2;
    sgn   = lowpass ? 1 : -1;
    base  = lowpass ? NUM_STG * NUM_CH : 0;
    stage = 0;
    if (ord > 2 * NUM_STG) ord = cbl_pkg::ORD_W'(2 * NUM_STG);
    if (ord == 0) return x;
    if (ord[0]) begin
      g  = longint'($signed(first[63:32]));
      a1 = longint'($signed(first[31:0]));
      x = filter_section(base + ch, x, g, sgn * g, 0, a1, 0);
      stage = 1;
    end
    b0 = longint'($signed(gain[63:32]));
    a1 = longint'($signed(gain[31:0]));
    a2 = longint'($signed(a2reg[31:0]));
    for (int k = 0; k < ord / 2; k++) begin
      x = filter_section(base + stage * NUM_CH + ch, x, b0, sgn * 2 * b0, b0, a1, a2);
      stage++;
    end
    return x;
  endfunction

  function automatic logic [23:0] band_limit(logic [2:0] ch, logic [23:0] smp);
    longint x;
    x = longint'($signed(smp));
    x = filter_cascade(1'b0, x, int'(ch));
    x = filter_cascade(1'b1, x, int'(ch));
    if (x > PORT_MAX) x = PORT_MAX;
    if (x < PORT_MIN) x = PORT_MIN;
    return x[23:0];
  endfunction

  // Offer one sample. tvalid is left high after the transaction so that a following
  // call can present the next item in the same time step; anything else that follows
  // lowers it first.
  task automatic send_sample(logic [2:0] ch, logic [23:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk); while (!s_axis_tready);
    expected_samples.push_back(band_limit(ch, smp));
  endtask

  // Stop offering input, wait for every expected result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller has drained the block beforehand.
  task automatic write_reg(logic [cbl_pkg::IDX_W-1:0] idx, logic [cbl_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coefficients of several kinds: full range, extremes, small and moderate values.
  function automatic logic [31:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0: return r;
      1: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h4000_0000;
           default: return 32'h0;
         endcase
      2: return $signed(r) >>> $urandom_range(2, 10);
      default: return $signed(r) >>> 1;
    endcase
  endfunction

  function automatic logic [23:0] rand_sample();
    logic [23:0] r;
    r = 24'($urandom);
    if ($urandom_range(3) == 0) return $signed(r) >>> $urandom_range(1, 12);
    return r;
  endfunction

  // Most phases use small orders so that the run stays short; some go past the limit.
  function automatic logic [cbl_pkg::CFG_W-1:0] rand_order();
    logic [cbl_pkg::CFG_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(4) == 0) return {v[63:4], 4'($urandom_range(0, 15))};
    return {v[63:4], 4'($urandom_range(0, 4))};
  endfunction

  task automatic random_config();
    write_reg(cbl_pkg::REG_HP_FIRST, {rand_coef(), rand_coef()});
    write_reg(cbl_pkg::REG_HP_GAIN,  {rand_coef(), rand_coef()});
    write_reg(cbl_pkg::REG_HP_A2,    {32'($urandom), rand_coef()});
    write_reg(cbl_pkg::REG_LP_FIRST, {rand_coef(), rand_coef()});
    write_reg(cbl_pkg::REG_LP_GAIN,  {rand_coef(), rand_coef()});
    write_reg(cbl_pkg::REG_LP_A2,    {32'($urandom), rand_coef()});
    write_reg(cbl_pkg::REG_HP_ORDER, rand_order());
    write_reg(cbl_pkg::REG_LP_ORDER, rand_order());
  endtask

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Each output transaction is compared with the oldest expected sample.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected output sample, actual %h", $realtime, m_axis_tdata);
        error_count++;
      end else begin
        if (m_axis_tdata !== expected_samples[0]) begin
          $display("%0t: sample_out mismatch, expected %h actual %h",
                   $realtime, expected_samples[0], m_axis_tdata);
          error_count++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_cascaded_biquad_band_limiter_unit: errors");
      $finish;
    end
  end

  // With both orders at reset value the block must pass samples through unchanged.
  task automatic test_bypass();
    send_sample(3'd0, 24'h7F_FFFF);
    send_sample(3'd7, 24'h80_0000);
    send_sample(3'd3, 24'h00_0000);
    send_sample(3'd4, 24'hFF_FFFF);
    send_sample(3'd5, 24'h55_5555);
    send_sample(3'd2, 24'hAA_AAAA);
    drain();
  endtask

  // Odd orders, the order saturation and extremes at the sample limits.
  task automatic test_directed_orders();
    write_reg(cbl_pkg::REG_HP_FIRST, {32'h3C00_0000, 32'hC400_0000});
    write_reg(cbl_pkg::REG_HP_GAIN,  {32'h3A00_0000, 32'h8C00_0000});
    write_reg(cbl_pkg::REG_HP_A2,    {32'hFFFF_FFFF, 32'h3200_0000});
    write_reg(cbl_pkg::REG_LP_FIRST, {32'h0200_0000, 32'hC400_0000});
    write_reg(cbl_pkg::REG_LP_GAIN,  {32'h0100_0000, 32'h9000_0000});
    write_reg(cbl_pkg::REG_LP_A2,    {32'h1234_5678, 32'h3000_0000});
    write_reg(cbl_pkg::REG_HP_ORDER, 64'd1);
    write_reg(cbl_pkg::REG_LP_ORDER, 64'd3);
    send_sample(3'd0, 24'h7F_FFFF);
    send_sample(3'd0, 24'h80_0000);
    send_sample(3'd7, 24'h7F_FFFF);
    send_sample(3'd0, 24'h00_0001);
    drain();
    // Orders past the limit act as the largest order; 15 is the top of the field.
    write_reg(cbl_pkg::REG_HP_ORDER, 64'd9);
    write_reg(cbl_pkg::REG_LP_ORDER, 64'd15);
    send_sample(3'd1, 24'h7F_FFFF);
    send_sample(3'd1, 24'h80_0000);
    send_sample(3'd6, 24'h40_0000);
    drain();
    // A coefficient write keeps the history, so this sample still sees the earlier ones.
    write_reg(cbl_pkg::REG_LP_GAIN, {32'h7FFF_FFFF, 32'h8000_0000});
    send_sample(3'd1, 24'h12_3456);
    drain();
    // Writes past the last register are dropped.
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '1);
    send_sample(3'd1, 24'hFE_DCBA);
    send_sample(3'd7, 24'h80_0000);
    drain();
  endtask

  // Settings change between phases; the streaming mostly uses a few channels so that
  // history builds up in each of them.
  task automatic test_random_phases(int phases, int per_phase);
    logic [2:0] ch;
    for (int p = 0; p < phases; p++) begin
      random_config();
      for (int i = 0; i < per_phase; i++) begin
        ch = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
        send_sample(ch, rand_sample());
      end
      drain();
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering samples,
  // so the block fills and stalls its input.
  task automatic test_backpressure();
    random_config();
    src_idle_pct = 0;
    sink_hold    = 400;
    for (int i = 0; i < 30; i++) send_sample(3'($urandom), rand_sample());
    drain();
  endtask

  initial begin
    hp_ord = '0; lp_ord = '0;
    hp_first = '0; hp_gain = '0; hp_a2 = '0;
    lp_first = '0; lp_gain = '0; lp_a2 = '0;
    clear_history();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bypass();
    test_directed_orders();

    src_idle_pct = 14; sink_idle_pct = 53;
    test_random_phases(5, 130);
    src_idle_pct = 53; sink_idle_pct = 14;
    test_random_phases(5, 130);
    src_idle_pct = 0;  sink_idle_pct = 0;
    test_random_phases(5, 130);
    test_backpressure();

    drain();
    if (error_count == 0) begin
      $display("tb_cascaded_biquad_band_limiter_unit: clean");
    end else begin
      $display("tb_cascaded_biquad_band_limiter_unit: errors");
    end
    $finish;
  end

endmodule

FILE: cascaded_biquad_band_limiter_unit.f
design/cbl_pkg.sv
design/cbl_ram.sv
design/cbl_datapath.sv
design/cbl_ctrl.sv
design/cascaded_biquad_band_limiter_unit.sv
design/cbl_checker.sv
tb/tb_cascaded_biquad_band_limiter_unit.sv
